// ----- rtl/core/bfa_pkg.sv -----
package bfa_pkg;

    // default memory size in units
    localparam int unsigned MEM_UNITS_DEF = 256;

    localparam int unsigned SIZE_W = 9;
    localparam int unsigned BASE_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned POL_W  = 2;

    // fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POL_W-1:0] POL_WORST = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERSIZE = 2'd2;

    // request mode
    localparam logic MODE_FREE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_REDUCE,
        S_SCAN,
        S_DRAIN,
        S_CHECK,
        S_MARK,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_issue;
        logic              reduce;
        logic              mark_start;
        logic              mark_step;
        logic              clear_step;
        logic              resp_load;
        logic [STAT_W-1:0] resp_code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic oversize;
        logic size_zero;
        logic is_free;
        logic next_mode;
        logic base_ge;
        logic scan_last;
        logic have;
        logic mark_last;
        logic clear_last;
        logic out_blocked;
    } dp_sts_t;

endpackage

// ----- rtl/core/bitmap_fit_allocator.sv -----
// Bitmap run allocator: one occupancy bit per memory unit, held in a RAM.
// Request channel (in_valid/in_ready): mode 0 allocates run_size units,
// mode 1 frees run_size units starting at run_base (wrapping at the end).
// Result channel (out_valid/out_ready): status and found_base, one result
// per request, in order. fit_policy (first, next, best or worst fit) must be
// written via cfg_we/cfg_wdata while the block is idle; it does not enforce this.
// Work per request, N = MEM_UNITS:
//   first/best/worst allocate: a full scan of all N units, one unit per
//   cycle through the single RAM port, then the marking pass over the run.
//   next-fit allocate: the scan starts at the next-fit position, stops at the
//   first fit and may run run_size - 1 units past its start to catch a run
//   that wraps. free: N is subtracted from run_base until it is below N,
//   then the marking pass. errors (oversize, zero-size allocate): no scan.
// One request is in work at a time; in_ready is high only when idle.
// Reset clears the next-fit position and the policy, then a clearing pass
// writes zero to all N map entries with in_ready low.
// The result sits in an output register; if the receiver stalls, the block
// still takes and processes the next request, holding its result until the
// output register frees up.
module bitmap_fit_allocator #(
    parameter int unsigned MEM_UNITS = bfa_pkg::MEM_UNITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bfa_pkg::POL_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [bfa_pkg::SIZE_W-1:0]  run_size,
    input  logic [bfa_pkg::BASE_W-1:0]  run_base,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bfa_pkg::STAT_W-1:0]  status,
    output logic [bfa_pkg::BASE_W-1:0]  found_base
);

    bfa_pkg::dp_cmd_t cmd;
    bfa_pkg::dp_sts_t sts;

    // sequencer: clear pass, decode, base reduce, scan, drain, check, mark, respond
    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // map RAM, scan trackers, next-fit pointer, result register
    bfa_datapath #(
        .MEM_UNITS (MEM_UNITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mode       (mode),
        .run_size   (run_size),
        .run_base   (run_base),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .found_base (found_base),
        .cmd        (cmd),
        .sts        (sts)
    );

    // one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another in work");

    // only defined status codes come out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == bfa_pkg::STAT_DONE || status == bfa_pkg::STAT_NOFIT ||
                       status == bfa_pkg::STAT_OVERSIZE))
        else $error("undefined status code");

    // base is zero unless the allocate succeeded
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != bfa_pkg::STAT_DONE) |-> (found_base == '0))
        else $error("nonzero base on failed request");

    // map is never written during a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> !(cmd.mark_step || cmd.clear_step))
        else $error("map write during scan");

endmodule

// ----- rtl/core/bfa_ram.sv -----
module bfa_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = bfa_pkg::MEM_UNITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bfa_datapath.sv -----
module bfa_datapath #(
    parameter int unsigned MEM_UNITS = bfa_pkg::MEM_UNITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bfa_pkg::POL_W-1:0]   cfg_wdata,
    input  logic                        mode,
    input  logic [bfa_pkg::SIZE_W-1:0]  run_size,
    input  logic [bfa_pkg::BASE_W-1:0]  run_base,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [bfa_pkg::STAT_W-1:0]  status,
    output logic [bfa_pkg::BASE_W-1:0]  found_base,
    input  bfa_pkg::dp_cmd_t            cmd,
    output bfa_pkg::dp_sts_t            sts
);

    localparam int unsigned AW = $clog2(MEM_UNITS);
    // wide enough for the longest next-fit scan index
    localparam int unsigned LW = $clog2(2 * MEM_UNITS + 512);
    localparam logic [LW-1:0] N_L    = LW'(MEM_UNITS);
    localparam logic [AW-1:0] LAST_A = AW'(MEM_UNITS - 1);

    logic [bfa_pkg::POL_W-1:0]  fit_policy_reg, fit_policy_next;
    logic                       mode_reg, mode_next;
    logic [LW-1:0]              size_reg, size_next;
    logic [bfa_pkg::BASE_W-1:0] rbase_reg, rbase_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [LW-1:0]              j_reg, j_next;
    logic                       pvalid_reg, pvalid_next;
    logic [AW-1:0]              paddr_reg, paddr_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [AW-1:0]              run_start_reg, run_start_next;
    logic                       have_reg, have_next;
    logic [LW-1:0]              best_len_reg, best_len_next;
    logic [AW-1:0]              best_base_reg, best_base_next;
    logic [LW-1:0]              cnt_reg, cnt_next;
    logic [AW-1:0]              nf_pos_reg, nf_pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bfa_pkg::STAT_W-1:0] status_reg, status_next;
    logic [bfa_pkg::BASE_W-1:0] found_reg, found_next;

    logic          ram_we;
    logic          ram_wdata;
    logic          ram_rdata;
    logic          next_mode;
    logic          is_free;
    logic [AW-1:0] addr_inc;
    logic [LW-1:0] j_last;
    logic [LW-1:0] rbase_w;
    logic [LW-1:0] rbase_sub;
    logic [LW-1:0] best_base_w;
    logic [LW-1:0] len_plus;
    logic          free_bit;
    logic          close_run;
    logic [LW-1:0] close_len;
    logic [AW-1:0] close_start;
    logic          qual;

    assign next_mode   = (fit_policy_reg == bfa_pkg::POL_NEXT);
    assign is_free     = (mode_reg == bfa_pkg::MODE_FREE);
    assign addr_inc    = (addr_reg == LAST_A) ? '0 : addr_reg + 1'b1;
    assign j_last      = next_mode ? (N_L + size_reg - LW'(2)) : (N_L - LW'(1));
    assign rbase_w     = LW'(rbase_reg);
    assign rbase_sub   = rbase_w - N_L;
    assign best_base_w = LW'(best_base_reg);
    assign len_plus    = len_reg + LW'(1);
    assign free_bit    = !ram_rdata;
    assign close_run   = !free_bit || (paddr_reg == LAST_A);
    assign close_len   = free_bit ? len_plus : len_reg;
    assign close_start = (free_bit && len_reg == '0) ? paddr_reg : run_start_reg;

    always_comb
    begin
        case (fit_policy_reg)
            bfa_pkg::POL_FIRST: qual = !have_reg;
            bfa_pkg::POL_BEST:  qual = !have_reg || (close_len < best_len_reg);
            bfa_pkg::POL_WORST: qual = !have_reg || (close_len > best_len_reg);
            bfa_pkg::POL_NEXT:  qual = 1'b0;
            default:            qual = 1'b0;
        endcase
    end

    assign ram_we    = cmd.mark_step || cmd.clear_step;
    assign ram_wdata = cmd.mark_step && !is_free;

    bfa_ram #(
        .WIDTH (1),
        .DEPTH (MEM_UNITS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fit_policy_next = fit_policy_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        rbase_next      = rbase_reg;
        addr_next       = addr_reg;
        j_next          = j_reg;
        pvalid_next     = cmd.scan_issue;
        paddr_next      = addr_reg;
        len_next        = len_reg;
        run_start_next  = run_start_reg;
        have_next       = have_reg;
        best_len_next   = best_len_reg;
        best_base_next  = best_base_reg;
        cnt_next        = cnt_reg;
        nf_pos_next     = nf_pos_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        found_next      = found_reg;

        if (cfg_we)
        begin
            fit_policy_next = cfg_wdata;
        end

        if (cmd.load)
        begin
            mode_next  = mode;
            size_next  = LW'(run_size);
            rbase_next = run_base;
        end

        if (cmd.reduce)
        begin
            rbase_next = rbase_sub[bfa_pkg::BASE_W-1:0];
        end

        // hole tracking on the word read in the previous cycle
        if (pvalid_reg && !next_mode)
        begin
            if (free_bit)
            begin
                len_next = len_plus;
                if (len_reg == '0)
                begin
                    run_start_next = paddr_reg;
                end
            end
            else
            begin
                len_next = '0;
            end
            if (close_run && (close_len >= size_reg) && qual)
            begin
                have_next      = 1'b1;
                best_len_next  = close_len;
                best_base_next = close_start;
            end
        end

        // next fit: stop at the first stretch that reaches the size
        if (pvalid_reg && next_mode && !have_reg)
        begin
            if (free_bit)
            begin
                len_next = len_plus;
                if (len_reg == '0)
                begin
                    run_start_next = paddr_reg;
                end
                if (len_plus == size_reg)
                begin
                    have_next      = 1'b1;
                    best_base_next = (len_reg == '0) ? paddr_reg : run_start_reg;
                end
            end
            else
            begin
                len_next = '0;
            end
        end

        if (cmd.scan_start)
        begin
            addr_next     = next_mode ? nf_pos_reg : '0;
            j_next        = '0;
            len_next      = '0;
            have_next     = 1'b0;
            best_len_next = '0;
        end

        if (cmd.scan_issue)
        begin
            addr_next = addr_inc;
            j_next    = j_reg + LW'(1);
        end

        if (cmd.mark_start)
        begin
            addr_next = is_free ? rbase_w[AW-1:0] : best_base_reg;
            cnt_next  = size_reg;
        end

        if (cmd.mark_step)
        begin
            addr_next = addr_inc;
            cnt_next  = cnt_reg - LW'(1);
            if (cnt_reg == LW'(1) && !is_free && next_mode)
            begin
                nf_pos_next = addr_inc;
            end
        end

        if (cmd.clear_step)
        begin
            addr_next = addr_inc;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.resp_load)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.resp_code;
            if (cmd.resp_code == bfa_pkg::STAT_DONE && !is_free)
            begin
                found_next = best_base_w[bfa_pkg::BASE_W-1:0];
            end
            else
            begin
                found_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= bfa_pkg::POL_FIRST;
            mode_reg       <= 1'b0;
            size_reg       <= '0;
            rbase_reg      <= '0;
            addr_reg       <= '0;
            j_reg          <= '0;
            pvalid_reg     <= 1'b0;
            paddr_reg      <= '0;
            len_reg        <= '0;
            run_start_reg  <= '0;
            have_reg       <= 1'b0;
            best_len_reg   <= '0;
            best_base_reg  <= '0;
            cnt_reg        <= '0;
            nf_pos_reg     <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= bfa_pkg::STAT_DONE;
            found_reg      <= '0;
        end
        else
        begin
            fit_policy_reg <= fit_policy_next;
            mode_reg       <= mode_next;
            size_reg       <= size_next;
            rbase_reg      <= rbase_next;
            addr_reg       <= addr_next;
            j_reg          <= j_next;
            pvalid_reg     <= pvalid_next;
            paddr_reg      <= paddr_next;
            len_reg        <= len_next;
            run_start_reg  <= run_start_next;
            have_reg       <= have_next;
            best_len_reg   <= best_len_next;
            best_base_reg  <= best_base_next;
            cnt_reg        <= cnt_next;
            nf_pos_reg     <= nf_pos_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_base = found_reg;

    assign sts.oversize    = (size_reg > N_L);
    assign sts.size_zero   = (size_reg == '0);
    assign sts.is_free     = is_free;
    assign sts.next_mode   = next_mode;
    assign sts.base_ge     = (rbase_w >= N_L);
    assign sts.scan_last   = (j_reg == j_last);
    assign sts.have        = have_reg;
    assign sts.mark_last   = (cnt_reg == LW'(1));
    assign sts.clear_last  = (addr_reg == LAST_A);
    assign sts.out_blocked = out_valid_reg && !out_ready;

endmodule

// ----- rtl/core/bfa_ctrl.sv -----
module bfa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bfa_pkg::dp_sts_t sts,
    output bfa_pkg::dp_cmd_t cmd
);

    bfa_pkg::state_t            state_reg, state_next;
    logic [bfa_pkg::STAT_W-1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfa_pkg::S_CLEAR;
            code_reg  <= bfa_pkg::STAT_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.resp_code = code_reg;
        in_ready      = 1'b0;

        unique case (state_reg)
            bfa_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bfa_pkg::S_DECODE;
                end
            end
            bfa_pkg::S_DECODE:
            begin
                if (sts.oversize)
                begin
                    code_next  = bfa_pkg::STAT_OVERSIZE;
                    state_next = bfa_pkg::S_RESP;
                end
                else if (sts.is_free)
                begin
                    code_next  = bfa_pkg::STAT_DONE;
                    state_next = sts.size_zero ? bfa_pkg::S_RESP : bfa_pkg::S_REDUCE;
                end
                else if (sts.size_zero)
                begin
                    code_next  = bfa_pkg::STAT_NOFIT;
                    state_next = bfa_pkg::S_RESP;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = bfa_pkg::S_SCAN;
                end
            end
            bfa_pkg::S_REDUCE:
            begin
                if (sts.base_ge)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = bfa_pkg::S_MARK;
                end
            end
            bfa_pkg::S_SCAN:
            begin
                if (sts.next_mode && sts.have)
                begin
                    state_next = bfa_pkg::S_CHECK;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = bfa_pkg::S_DRAIN;
                    end
                end
            end
            bfa_pkg::S_DRAIN:
            begin
                state_next = bfa_pkg::S_CHECK;
            end
            bfa_pkg::S_CHECK:
            begin
                if (sts.have)
                begin
                    code_next      = bfa_pkg::STAT_DONE;
                    cmd.mark_start = 1'b1;
                    state_next     = bfa_pkg::S_MARK;
                end
                else
                begin
                    code_next  = bfa_pkg::STAT_NOFIT;
                    state_next = bfa_pkg::S_RESP;
                end
            end
            bfa_pkg::S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last)
                begin
                    state_next = bfa_pkg::S_RESP;
                end
            end
            bfa_pkg::S_RESP:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = bfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule
